// ----- hw/rtl/zcrs_pkg.sv -----
// zcrs_pkg: shared types and constants of the zero-cross relay sequencer
// used by zcrs_config, zcrs_core and zero_cross_relay_sequencer_top
// no dependencies
`default_nettype none

package zcrs_pkg;

  // fixed width of every counter field on the result channel
  localparam int FIELD_W = 32;

  // item kinds (in_tuser)
  localparam logic [1:0] KIND_CROSS    = 2'd0;
  localparam logic [1:0] KIND_FEEDBACK = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  // heating commands
  localparam logic [1:0] CMD_OFF   = 2'd0;
  localparam logic [1:0] CMD_ON    = 2'd1;
  localparam logic [1:0] CMD_PAUSE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_TPS      = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF  = 2'd2;

  // configuration reset values
  localparam logic [3:0]  DEBOUNCE_RST = 4'd2;
  localparam logic [15:0] TPS_RST      = 16'd1000;
  localparam logic [15:0] HOLDOFF_RST  = 16'd20;

  typedef struct packed {
    logic [3:0]  debounce_limit;
    logic [15:0] ticks_per_second;
    logic [15:0] fault_holdoff;
  } cfg_t;

  // one result item, counters already extended to field width
  typedef struct packed {
    logic [FIELD_W-1:0] stuck_closed_count;
    logic [FIELD_W-1:0] stuck_open_count;
    logic [FIELD_W-1:0] contact_seconds;
    logic [FIELD_W-1:0] drive_seconds;
    logic [FIELD_W-1:0] contact_count;
    logic [FIELD_W-1:0] start_count;
    logic               pulse_drive;
    logic               relay_drive;
    logic [1:0]         mode;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/zcrs_config.sv -----
// zcrs_config: configuration registers, written through a plain write port
// depends on zcrs_pkg
`default_nettype none

module zcrs_config
  import zcrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit   <= DEBOUNCE_RST;
      cfg_r.ticks_per_second <= TPS_RST;
      cfg_r.fault_holdoff    <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEBOUNCE: cfg_r.debounce_limit   <= cfg_wdata[3:0];
        CFG_TPS:      cfg_r.ticks_per_second <= cfg_wdata;
        CFG_HOLDOFF:  cfg_r.fault_holdoff    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/zcrs_core.sv -----
// zcrs_core: sequencer state, counters and the single-pass update for one item
// depends on zcrs_pkg
`default_nettype none

module zcrs_core
  import zcrs_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       commit,
  input  wire logic [1:0] kind,
  input  wire logic [1:0] boil_command,
  input  wire logic       feedback_high,
  output result_t         result
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_RELAY = 2'd2,
    MODE_BOIL  = 2'd3
  } mode_t;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  mode_t       mode_r, mode_nxt;
  logic [3:0]  agree_on_r, agree_on_nxt;
  logic [3:0]  agree_off_r, agree_off_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic        relay_r, relay_nxt;
  logic        pulse_r, pulse_nxt;
  cnt_t        start_r, start_nxt;
  cnt_t        contact_r, contact_nxt;
  cnt_t        drive_s_r, drive_s_nxt;
  cnt_t        contact_s_r, contact_s_nxt;
  cnt_t        open_r, open_nxt;
  cnt_t        closed_r, closed_nxt;
  logic [15:0] hold_open_r, hold_open_nxt;
  logic [15:0] hold_closed_r, hold_closed_nxt;

  logic [1:0]  cmd;
  logic [4:0]  on_inc, off_inc;
  logic        on_hit, off_hit;
  logic [3:0]  on_keep, off_keep;
  logic [31:0] since_mark;
  logic        second_due;

  // command three acts as pause
  assign cmd = (boil_command == CMD_OFF || boil_command == CMD_ON) ? boil_command : CMD_PAUSE;

  // debounce: one more agreeing crossing, hit when it passes the limit
  assign on_inc   = {1'b0, agree_on_r} + 5'd1;
  assign off_inc  = {1'b0, agree_off_r} + 5'd1;
  assign on_hit   = on_inc > {1'b0, cfg.debounce_limit};
  assign off_hit  = off_inc > {1'b0, cfg.debounce_limit};
  assign on_keep  = on_inc[3:0];
  assign off_keep = off_inc[3:0];

  // second accounting against the last mark
  assign since_mark = tick_r - mark_r;
  assign second_due = since_mark > {16'd0, cfg.ticks_per_second};

  // next state for the item in the input register
  always_comb begin
    mode_nxt        = mode_r;
    agree_on_nxt    = agree_on_r;
    agree_off_nxt   = agree_off_r;
    tick_nxt        = tick_r;
    mark_nxt        = mark_r;
    relay_nxt       = relay_r;
    pulse_nxt       = pulse_r;
    start_nxt       = start_r;
    contact_nxt     = contact_r;
    drive_s_nxt     = drive_s_r;
    contact_s_nxt   = contact_s_r;
    open_nxt        = open_r;
    closed_nxt      = closed_r;
    hold_open_nxt   = hold_open_r;
    hold_closed_nxt = hold_closed_r;

    unique case (kind)
      KIND_CROSS: begin
        unique case (mode_r)
          MODE_IDLE: begin
            relay_nxt     = 1'b0;
            pulse_nxt     = 1'b0;
            agree_on_nxt  = '0;
            agree_off_nxt = '0;
            if (cmd == CMD_ON) begin
              mode_nxt = MODE_PULSE;
            end
          end
          MODE_PULSE: begin
            if (cmd == CMD_OFF) begin
              agree_on_nxt = '0;
              if (off_hit) begin
                agree_off_nxt = '0;
                pulse_nxt     = 1'b0;
                mode_nxt      = MODE_IDLE;
              end else begin
                agree_off_nxt = off_keep;
              end
            end else begin
              agree_off_nxt = '0;
              if (on_hit) begin
                agree_on_nxt = '0;
                pulse_nxt    = 1'b1;
                start_nxt    = start_r + cnt_t'(1);
                mode_nxt     = MODE_RELAY;
              end else begin
                agree_on_nxt = on_keep;
              end
            end
          end
          MODE_RELAY: begin
            if (cmd == CMD_OFF) begin
              agree_on_nxt = '0;
              if (off_hit) begin
                agree_off_nxt = '0;
                relay_nxt     = 1'b0;
                mode_nxt      = MODE_PULSE;
              end else begin
                agree_off_nxt = off_keep;
              end
            end else if (cmd == CMD_ON) begin
              agree_off_nxt = '0;
              if (on_hit) begin
                agree_on_nxt = '0;
                relay_nxt    = 1'b1;
                mark_nxt     = tick_r;
                contact_nxt  = contact_r + cnt_t'(1);
                mode_nxt     = MODE_BOIL;
              end else begin
                agree_on_nxt = on_keep;
              end
            end else if (second_due) begin
              // pause leaves the agree counts alone
              mark_nxt    = tick_r;
              drive_s_nxt = drive_s_r + cnt_t'(1);
            end
          end
          MODE_BOIL: begin
            if (cmd != CMD_ON) begin
              agree_on_nxt = '0;
              if (off_hit) begin
                agree_off_nxt = '0;
                relay_nxt     = 1'b0;
                mode_nxt      = MODE_RELAY;
              end else begin
                agree_off_nxt = off_keep;
              end
            end else begin
              if (second_due) begin
                mark_nxt      = tick_r;
                contact_s_nxt = contact_s_r + cnt_t'(1);
                drive_s_nxt   = drive_s_r + cnt_t'(1);
              end
              agree_off_nxt = '0;
              relay_nxt     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      KIND_FEEDBACK: begin
        if (mode_r == MODE_BOIL) begin
          // stuck open: pin stays high while boiling
          if (feedback_high) begin
            if (hold_open_r == '0) begin
              open_nxt      = open_r + cnt_t'(1);
              hold_open_nxt = cfg.fault_holdoff;
            end
          end else begin
            open_nxt = '0;
          end
        end else begin
          // stuck closed: pin low in any other mode
          if (feedback_high) begin
            closed_nxt = '0;
          end else if (hold_closed_r == '0) begin
            closed_nxt      = closed_r + cnt_t'(1);
            hold_closed_nxt = cfg.fault_holdoff;
          end
        end
      end
      KIND_TICK: begin
        tick_nxt = tick_r + 32'd1;
        if (hold_open_r != '0) begin
          hold_open_nxt = hold_open_r - 16'd1;
        end
        if (hold_closed_r != '0) begin
          hold_closed_nxt = hold_closed_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  // state update on each committed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      agree_on_r    <= '0;
      agree_off_r   <= '0;
      tick_r        <= '0;
      mark_r        <= '0;
      relay_r       <= 1'b0;
      pulse_r       <= 1'b0;
      start_r       <= '0;
      contact_r     <= '0;
      drive_s_r     <= '0;
      contact_s_r   <= '0;
      open_r        <= '0;
      closed_r      <= '0;
      hold_open_r   <= '0;
      hold_closed_r <= '0;
    end else if (commit) begin
      mode_r        <= mode_nxt;
      agree_on_r    <= agree_on_nxt;
      agree_off_r   <= agree_off_nxt;
      tick_r        <= tick_nxt;
      mark_r        <= mark_nxt;
      relay_r       <= relay_nxt;
      pulse_r       <= pulse_nxt;
      start_r       <= start_nxt;
      contact_r     <= contact_nxt;
      drive_s_r     <= drive_s_nxt;
      contact_s_r   <= contact_s_nxt;
      open_r        <= open_nxt;
      closed_r      <= closed_nxt;
      hold_open_r   <= hold_open_nxt;
      hold_closed_r <= hold_closed_nxt;
    end
  end

  // result reports the state after the update
  always_comb begin
    result.mode               = mode_nxt;
    result.relay_drive        = relay_nxt;
    result.pulse_drive        = pulse_nxt;
    result.start_count        = FIELD_W'(start_nxt);
    result.contact_count      = FIELD_W'(contact_nxt);
    result.drive_seconds      = FIELD_W'(drive_s_nxt);
    result.contact_seconds    = FIELD_W'(contact_s_nxt);
    result.stuck_open_count   = FIELD_W'(open_nxt);
    result.stuck_closed_count = FIELD_W'(closed_nxt);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/zero_cross_relay_sequencer_top.sv -----
// zero_cross_relay_sequencer_top: input register, sequencer core, result register
// depends on zcrs_pkg, zcrs_config, zcrs_core
//
//   channel  direction  payload
//   in_*     slave      tuser: kind; tdata: boil_command, feedback_high
//   out_*    master     tdata: mode, drives and six counters
//   cfg_*    write      index 0 debounce, 1 ticks per second, 2 fault holdoff
//
// one item per cycle sustained while out_tready stays high; the result of an item passes
// through the input register, then the result register
// the update is one pass of logic from the input register to the result register
// a stalled result holds the input register, which, while it holds an item, holds in_tready low
// reset is synchronous and active low and takes effect on the next clock edge
`default_nettype none

module zero_cross_relay_sequencer_top
  import zcrs_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration write
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,  // boil_command[1:0], feedback_high[2], zero pad
  input  wire logic [1:0]   in_tuser,  // kind[1:0]
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata  // mode[1:0], relay_drive[2], pulse_drive[3],
                                       // start_count[35:4], contact_count[67:36],
                                       // drive_seconds[99:68], contact_seconds[131:100],
                                       // stuck_open_count[163:132],
                                       // stuck_closed_count[195:164], zero pad
);

  cfg_t       cfg;
  result_t    result;
  logic       item_valid_r;
  logic [1:0] kind_r;
  logic [1:0] cmd_r;
  logic       fb_r;
  logic       out_valid_r;
  result_t    out_data_r;
  logic       commit;

  zcrs_config u_config (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // item moves on when the result register is free or being drained
  assign commit    = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || commit;

  zcrs_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .commit        (commit),
    .kind          (kind_r),
    .boil_command  (cmd_r),
    .feedback_high (fb_r),
    .result        (result)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      cmd_r  <= in_tdata[1:0];
      fb_r   <= in_tdata[2];
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for zero_cross_relay_sequencer_top
// predicts every result from its own heater sequencer model and checks the out_ stream
// depends on zcrs_pkg and the sequencer rtl
`timescale 1ns / 100ps

module tb;
  import zcrs_pkg::*;

  // codes the package does not name
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [1:0] CMD_PAUSE_ALT = 2'd3;
  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_PULSE    = 2'd1;
  localparam logic [1:0] MODE_RELAY    = 2'd2;
  localparam logic [1:0] MODE_BOIL     = 2'd3;

  localparam int unsigned QUIET_LIMIT = 1000;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [1:0]   cfg_addr   = 2'd0;
  logic [15:0]  cfg_wdata  = 16'd0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'd0;  // boil_command[1:0], feedback_high[2], zero pad
  logic [1:0]   in_tuser   = 2'd0;  // kind[1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;          // result_t in [195:0], zero pad above

  zero_cross_relay_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sequencer model: settings and state as seen after reset
  logic [3:0]  set_debounce = DEBOUNCE_RST;
  logic [15:0] set_tps      = TPS_RST;
  logic [15:0] set_holdoff  = HOLDOFF_RST;

  logic [1:0]  heat_mode      = MODE_IDLE;
  logic [3:0]  agree_on_run   = 4'd0;
  logic [3:0]  agree_off_run  = 4'd0;
  logic [31:0] tick_total     = 32'd0;
  logic [31:0] sec_mark_at    = 32'd0;
  logic        coil_on        = 1'b0;
  logic        pulse_on       = 1'b0;
  logic [31:0] starts_total   = 32'd0;
  logic [31:0] contacts_total = 32'd0;
  logic [31:0] drive_secs     = 32'd0;
  logic [31:0] contact_secs   = 32'd0;
  logic [31:0] open_faults    = 32'd0;
  logic [31:0] closed_faults  = 32'd0;
  logic [15:0] open_holdoff   = 16'd0;
  logic [15:0] closed_holdoff = 16'd0;

  result_t     heater_expect_q[$];

  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned boil_entries;
  int unsigned quiet_cycles;
  int unsigned stall_left;

  // one more agreeing crossing; hit when the run exceeds the debounce limit
  task automatic agree_step(inout logic [3:0] run, output bit hit);
    logic [4:0] nxt;
    nxt = {1'b0, run} + 5'd1;
    hit = (nxt > {1'b0, set_debounce});
    run = hit ? 4'd0 : nxt[3:0];
  endtask

  // a second is due once more than ticks_per_second ticks passed since the mark
  function automatic bit second_elapsed();
    if (tick_total - sec_mark_at > {16'd0, set_tps}) begin
      sec_mark_at = tick_total;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic advance_heater(input logic [1:0] kind, input logic [1:0] cmd,
                                input logic fb, output result_t r);
    logic [1:0] c;
    bit hit;
    case (kind)
      KIND_CROSS: begin
        // command three acts as pause
        c = (cmd == CMD_OFF || cmd == CMD_ON) ? cmd : CMD_PAUSE;
        case (heat_mode)
          MODE_IDLE: begin
            coil_on = 1'b0;
            pulse_on = 1'b0;
            agree_on_run = 4'd0;
            agree_off_run = 4'd0;
            if (c == CMD_ON) heat_mode = MODE_PULSE;
          end
          MODE_PULSE: begin
            if (c == CMD_OFF) begin
              agree_on_run = 4'd0;
              agree_step(agree_off_run, hit);
              if (hit) begin
                pulse_on = 1'b0;
                heat_mode = MODE_IDLE;
              end
            end else begin
              // pause agrees with on here
              agree_off_run = 4'd0;
              agree_step(agree_on_run, hit);
              if (hit) begin
                pulse_on = 1'b1;
                starts_total++;
                heat_mode = MODE_RELAY;
              end
            end
          end
          MODE_RELAY: begin
            if (c == CMD_OFF) begin
              agree_on_run = 4'd0;
              agree_step(agree_off_run, hit);
              if (hit) begin
                coil_on = 1'b0;
                heat_mode = MODE_PULSE;
              end
            end else if (c == CMD_ON) begin
              agree_off_run = 4'd0;
              agree_step(agree_on_run, hit);
              if (hit) begin
                coil_on = 1'b1;
                sec_mark_at = tick_total;
                contacts_total++;
                boil_entries++;
                heat_mode = MODE_BOIL;
              end
            end else begin
              // pause keeps the runs, counts drive time against a possibly old mark
              if (second_elapsed()) drive_secs++;
            end
          end
          default: begin
            if (c != CMD_ON) begin
              agree_on_run = 4'd0;
              agree_step(agree_off_run, hit);
              if (hit) begin
                coil_on = 1'b0;
                heat_mode = MODE_RELAY;
              end
            end else begin
              if (second_elapsed()) begin
                contact_secs++;
                drive_secs++;
              end
              agree_off_run = 4'd0;
              coil_on = 1'b1;
            end
          end
        endcase
      end
      KIND_FEEDBACK: begin
        if (heat_mode == MODE_BOIL) begin
          if (!fb) open_faults = 32'd0;
          else if (open_holdoff == 16'd0) begin
            open_faults++;
            open_holdoff = set_holdoff;
          end
        end else begin
          if (fb) closed_faults = 32'd0;
          else if (closed_holdoff == 16'd0) begin
            closed_faults++;
            closed_holdoff = set_holdoff;
          end
        end
      end
      KIND_TICK: begin
        tick_total++;
        if (open_holdoff != 16'd0) open_holdoff--;
        if (closed_holdoff != 16'd0) closed_holdoff--;
      end
      default: ;  // unused kind leaves everything as it is
    endcase
    r.mode               = heat_mode;
    r.relay_drive        = coil_on;
    r.pulse_drive        = pulse_on;
    r.start_count        = starts_total;
    r.contact_count      = contacts_total;
    r.drive_seconds      = drive_secs;
    r.contact_seconds    = contact_secs;
    r.stuck_open_count   = open_faults;
    r.stuck_closed_count = closed_faults;
  endtask

  // ---------------------------------------------------------------------------
  // idle lengths: mostly short, now and then long
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // result sink back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (heater_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result transfer with none pending", $time);
      end else begin
        want = heater_expect_q.pop_front();
        check_field("mode", 32'(want.mode), 32'(got.mode));
        check_field("relay_drive", 32'(want.relay_drive), 32'(got.relay_drive));
        check_field("pulse_drive", 32'(want.pulse_drive), 32'(got.pulse_drive));
        check_field("start_count", want.start_count, got.start_count);
        check_field("contact_count", want.contact_count, got.contact_count);
        check_field("drive_seconds", want.drive_seconds, got.drive_seconds);
        check_field("contact_seconds", want.contact_seconds, got.contact_seconds);
        check_field("stuck_open_count", want.stuck_open_count, got.stuck_open_count);
        check_field("stuck_closed_count", want.stuck_closed_count, got.stuck_closed_count);
      end
      results_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, heater_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // one input transfer, then maybe a gap; valid stays high when no gap follows
  task automatic send_item(input logic [1:0] kind, input logic [1:0] cmd, input logic fb);
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b00000, fb, cmd};
    do @(posedge clk); while (!in_tready);
    advance_heater(kind, cmd, fb, r);
    heater_expect_q.push_back(r);
    items_sent++;
    if (src_gaps && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted result has been seen
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (heater_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers back to back while the block is idle
  task automatic program_regs(input logic [3:0] dl, input logic [15:0] tps,
                              input logic [15:0] ho, input bit poke_unused);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DEBOUNCE;
    cfg_wdata <= {12'($urandom()), dl};  // upper bits must be dropped
    @(posedge clk);
    set_debounce = dl;
    cfg_addr  <= CFG_TPS;
    cfg_wdata <= tps;
    @(posedge clk);
    set_tps = tps;
    cfg_addr  <= CFG_HOLDOFF;
    cfg_wdata <= ho;
    @(posedge clk);
    set_holdoff = ho;
    if (poke_unused) begin
      // index past the last register is ignored
      cfg_addr  <= CFG_UNUSED;
      cfg_wdata <= 16'($urandom());
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // bursts that lean toward heating up, holding, cooling down, or pure noise
  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent, burst, lean, roll;
    bit          paused;
    logic [1:0]  kind, cmd, pause_cmd;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      lean = $urandom_range(0, 3);
      burst = $urandom_range(8, 40);
      if (burst > n_items - sent) burst = n_items - sent;
      src_gaps = ($urandom_range(0, 4) != 0);
      sink_stalls = ($urandom_range(0, 4) != 0);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        kind = (roll < 50) ? KIND_CROSS : (roll < 78) ? KIND_TICK :
               (roll < 95) ? KIND_FEEDBACK : KIND_UNUSED;
        pause_cmd = ($urandom_range(0, 1) != 0) ? CMD_PAUSE : CMD_PAUSE_ALT;
        roll = $urandom_range(0, 99);
        case (lean)
          0: cmd = (roll < 85) ? CMD_ON : (roll < 95) ? pause_cmd : CMD_OFF;
          1: cmd = (roll < 50) ? CMD_ON : (roll < 90) ? pause_cmd : CMD_OFF;
          2: cmd = (roll < 80) ? CMD_OFF : (roll < 95) ? pause_cmd : CMD_ON;
          default: cmd = 2'($urandom_range(0, 3));
        endcase
        send_item(kind, cmd, 1'($urandom_range(0, 1)));
        if (kind != KIND_UNUSED) sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // directed walk through every mode, command, kind and fault path
  task automatic test_directed_walk();
    // reset settings: ignored kind, feedback in idle, debounce of two on the way up
    send_item(KIND_UNUSED, CMD_PAUSE_ALT, 1'b1);
    send_item(KIND_FEEDBACK, CMD_OFF, 1'b1);
    send_item(KIND_CROSS, CMD_ON, 1'b0);
    send_item(KIND_CROSS, CMD_ON, 1'b0);
    send_item(KIND_CROSS, CMD_PAUSE, 1'b0);
    send_item(KIND_CROSS, CMD_ON, 1'b0);
    // no debounce, zero ticks per second, short holdoff
    program_regs(4'd0, 16'd0, 16'd2, 1'b0);
    send_item(KIND_TICK, CMD_OFF, 1'b0);
    send_item(KIND_CROSS, CMD_PAUSE_ALT, 1'b0);  // stale second mark in relay start
    send_item(KIND_CROSS, CMD_ON, 1'b0);
    send_item(KIND_TICK, CMD_OFF, 1'b0);
    send_item(KIND_CROSS, CMD_ON, 1'b0);
    send_item(KIND_FEEDBACK, CMD_OFF, 1'b1);     // stuck open
    send_item(KIND_FEEDBACK, CMD_OFF, 1'b1);     // held off
    send_item(KIND_FEEDBACK, CMD_OFF, 1'b0);     // clears stuck open
    send_item(KIND_CROSS, CMD_OFF, 1'b0);
    send_item(KIND_FEEDBACK, CMD_OFF, 1'b0);     // stuck closed
    send_item(KIND_CROSS, CMD_OFF, 1'b0);
    send_item(KIND_CROSS, CMD_PAUSE, 1'b0);      // pause agrees toward relay start
    send_item(KIND_CROSS, CMD_OFF, 1'b0);
    send_item(KIND_CROSS, CMD_OFF, 1'b0);
    send_item(KIND_CROSS, CMD_PAUSE, 1'b0);      // pause in idle stays idle
    send_item(KIND_TICK, CMD_ON, 1'b1);
    send_item(KIND_TICK, CMD_ON, 1'b1);
    send_item(KIND_FEEDBACK, CMD_ON, 1'b0);
    send_item(KIND_FEEDBACK, CMD_ON, 1'b1);      // clears stuck closed
  endtask

  task automatic test_default_settings();
    program_regs(DEBOUNCE_RST, TPS_RST, HOLDOFF_RST, 1'b0);
    random_traffic(100);
  endtask

  task automatic test_fast_settings();
    program_regs(4'd0, 16'd0, 16'd0, 1'b0);
    random_traffic(150);
  endtask

  task automatic test_slow_settings();
    program_regs(4'd15, 16'hFFFF, 16'hFFFF, 1'b0);
    random_traffic(100);
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      program_regs(4'($urandom_range(0, 15)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 8)), 1'b0);
      random_traffic(60);
    end
  endtask

  task automatic test_unused_register();
    program_regs(4'd1, 16'd2, 16'd3, 1'b1);
    random_traffic(80);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_walk();
    test_default_settings();
    test_fast_settings();
    test_slow_settings();
    test_random_settings();
    test_unused_register();

    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("run: %0d items sent, %0d results checked, boiling entered %0d times",
             items_sent, results_checked, boil_entries);
    $display("run: %0d drive s, %0d contact s, last fault counts open %0d closed %0d",
             drive_secs, contact_secs, open_faults, closed_faults);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/zcrs_pkg.sv
hw/rtl/zcrs_config.sv
hw/rtl/zcrs_core.sv
hw/rtl/zero_cross_relay_sequencer_top.sv
bench/tb.sv
